/* rtl/alist_pkg.sv */
// alist_pkg: shared types, codes and sizes of the array list block
// item structs, operation and status codes, controller states, ram request
// no dependencies
package alist_pkg;

	localparam int DEPTH = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OP_W = 2;
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int STAT_W = 2;
	localparam int LEN_W = 7;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		logic [POS_W-1:0] position;
		logic signed [VAL_W-1:0] new_value;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic signed [VAL_W-1:0] out_value;
		logic [LEN_W-1:0] length;
	} out_item_t;

	typedef struct packed {
		logic we;
		logic [ADDR_W-1:0] waddr;
		logic [VAL_W-1:0] wdata;
		logic re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH,
		S_OUT
	} ctrl_state_t;

endpackage

/* rtl/array_list_insert_delete_top.sv */
// array_list_insert_delete_top: fixed-depth ordered list with insert, delete, read
// instantiates alist_ctrl and alist_ram, holds the output register
// depends on alist_pkg
//
// channel  | direction | handshake             | payload
// in       | input     | in_valid / in_stall   | in_item (operation, position, new_value)
// out      | output    | out_valid / out_stall | out_item (status, out_value, length)
//
// a read passes S_SCAN and S_FINISH to S_OUT, errors go from S_IDLE to S_OUT
// insert and delete move the elements from position p to the end in S_SCAN
// through the ram, one element read and one written per cycle
// reset clears the count and the control state; ram contents are not cleared
// out_stall holds the output register; the next item is still taken and worked on, its result waits in S_OUT

module array_list_insert_delete_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input alist_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output alist_pkg::out_item_t out_item
);
	import alist_pkg::*;

	ram_req_t ram_req;
	logic [VAL_W-1:0] ram_rdata;
	logic res_valid;
	logic res_take;
	out_item_t res_item;
	logic out_valid_q;
	out_item_t out_item_q;

	assign res_take = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	alist_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.ram_req(ram_req),
		.ram_rdata(ram_rdata),
		.res_valid(res_valid),
		.res_take(res_take),
		.res_item(res_item)
	);

	alist_ram #(
		.DEPTH_P(DEPTH),
		.WIDTH_P(VAL_W)
	) u_ram (
		.clk(clk),
		.we(ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.re(ram_req.re),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_item_q <= res_item;
		end
	end

endmodule

/* rtl/alist_ram.sv */
// alist_ram: generic simple dual-port ram, one write and one read port
// read data registered, held while re is low
// no dependencies
module alist_ram #(
	parameter int DEPTH_P = 64,
	parameter int WIDTH_P = 32,
	parameter int AW_P = $clog2(DEPTH_P)
) (
	input logic clk,
	input logic we,
	input logic [AW_P-1:0] waddr,
	input logic [WIDTH_P-1:0] wdata,
	input logic re,
	input logic [AW_P-1:0] raddr,
	output logic [WIDTH_P-1:0] rdata
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/alist_ctrl.sv */
// alist_ctrl: sequencer for insert, delete and read over the element ram
// moves one element per cycle, holds the element count
// depends on alist_pkg
module alist_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input alist_pkg::in_item_t in_item,
	output alist_pkg::ram_req_t ram_req,
	input logic [alist_pkg::VAL_W-1:0] ram_rdata,
	output logic res_valid,
	input logic res_take,
	output alist_pkg::out_item_t res_item
);
	import alist_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [OP_W-1:0] op_q, op_d;
	logic [ADDR_W-1:0] pos_q, pos_d;
	logic [VAL_W-1:0] val_q, val_d;
	logic [ADDR_W-1:0] ra_q, ra_d;
	logic pend_q, pend_d;
	logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
	logic cap_q, cap_d;
	logic [VAL_W-1:0] got_q, got_d;
	logic [STAT_W-1:0] stat_q, stat_d;
	logic [CMP_W-1:0] pos_x, cnt_x;
	logic [ADDR_W-1:0] last_addr;

	assign pos_x = CMP_W'(in_item.position);
	assign cnt_x = CMP_W'(cnt_q);
	assign last_addr = ADDR_W'(cnt_q - CNT_W'(1));
	assign in_stall = (state_q != S_IDLE);
	assign res_item.status = stat_q;
	assign res_item.out_value = got_q;
	assign res_item.length = LEN_W'(cnt_q);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		op_d = op_q;
		pos_d = pos_q;
		val_d = val_q;
		ra_d = ra_q;
		pend_d = 1'b0;
		pend_addr_d = pend_addr_q;
		cap_d = 1'b0;
		got_d = cap_q ? ram_rdata : got_q;
		stat_d = stat_q;
		res_valid = 1'b0;
		ram_req.we = pend_q;
		ram_req.waddr = pend_addr_q;
		ram_req.wdata = ram_rdata;
		ram_req.re = 1'b0;
		ram_req.raddr = ra_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d = in_item.operation;
					pos_d = ADDR_W'(in_item.position);
					val_d = in_item.new_value;
					stat_d = STAT_OK;
					got_d = '0;
					priority if (in_item.operation == OP_INSERT) begin
						priority if (pos_x > cnt_x) begin
							stat_d = STAT_RANGE;
							state_d = S_OUT;
						end else if (cnt_q == CNT_W'(DEPTH)) begin
							stat_d = STAT_FULL;
							state_d = S_OUT;
						end else if (cnt_x > pos_x) begin
							ra_d = last_addr;
							state_d = S_SCAN;
						end else begin
							state_d = S_FINISH;
						end
					end else if (in_item.operation == OP_DELETE ||
						in_item.operation == OP_READ) begin
						if (pos_x >= cnt_x) begin
							stat_d = STAT_RANGE;
							state_d = S_OUT;
						end else begin
							ra_d = ADDR_W'(in_item.position);
							state_d = S_SCAN;
						end
					end else begin
						stat_d = STAT_RANGE;
						state_d = S_OUT;
					end
				end
			end
			S_SCAN: begin
				ram_req.re = 1'b1;
				priority if (op_q == OP_INSERT) begin
					pend_d = 1'b1;
					pend_addr_d = ra_q + ADDR_W'(1);
					if (ra_q == pos_q) begin
						state_d = S_FINISH;
					end else begin
						ra_d = ra_q - ADDR_W'(1);
					end
				end else if (op_q == OP_DELETE) begin
					if (ra_q == pos_q) begin
						cap_d = 1'b1;
					end else begin
						pend_d = 1'b1;
						pend_addr_d = ra_q - ADDR_W'(1);
					end
					if (ra_q == last_addr) begin
						state_d = S_FINISH;
					end else begin
						ra_d = ra_q + ADDR_W'(1);
					end
				end else begin
					cap_d = 1'b1;
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!pend_q && !cap_q) begin
					state_d = S_OUT;
					priority if (op_q == OP_INSERT) begin
						ram_req.we = 1'b1;
						ram_req.waddr = pos_q;
						ram_req.wdata = val_q;
						cnt_d = cnt_q + CNT_W'(1);
					end else if (op_q == OP_DELETE) begin
						cnt_d = cnt_q - CNT_W'(1);
					end else begin
						cnt_d = cnt_q;
					end
				end
			end
			S_OUT: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			pend_q <= 1'b0;
			cap_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			pend_q <= pend_d;
			cap_q <= cap_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		pos_q <= pos_d;
		val_q <= val_d;
		ra_q <= ra_d;
		pend_addr_q <= pend_addr_d;
		got_q <= got_d;
		stat_q <= stat_d;
	end

endmodule

/* dv/tb_array_list_insert_delete_top.sv */
// tb_array_list_insert_delete_top: self-checking bench for the array list block
// a queue-fed driver and a monitor check every reply against an in-bench list model
// depends on alist_pkg and array_list_insert_delete_top
module tb_array_list_insert_delete_top;
	timeunit 1ns;
	timeprecision 1ps;

	import alist_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 385;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 80;
	localparam int REPORT_MAX = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;

	in_item_t op_queue[$];
	out_item_t list_replies[$];

	logic [VAL_W-1:0] list_mem [DEPTH];
	int list_len = 0;
	int plan_len = 0;
	bit growing = 1'b1;
	int gap_pct = 0;
	int stall_pct = 0;
	int fail_count = 0;
	int quiet_cycles = 0;

	array_list_insert_delete_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// expected reply of one item, updates the list copy
	function automatic out_item_t list_apply(in_item_t it);
		out_item_t r;
		int j;
		int p;
		p = int'(it.position);
		r.status = STAT_RANGE;
		r.out_value = '0;
		case (it.operation)
			OP_INSERT: begin
				if (p > list_len) begin
					r.status = STAT_RANGE;
				end else if (list_len >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					for (j = list_len; j > p; j--)
						list_mem[ADDR_W'(j)] = list_mem[ADDR_W'(j - 1)];
					list_mem[ADDR_W'(p)] = it.new_value;
					list_len++;
					r.status = STAT_OK;
				end
			end
			OP_DELETE, OP_READ: begin
				if (p < list_len) begin
					r.status = STAT_OK;
					r.out_value = list_mem[ADDR_W'(p)];
					if (it.operation == OP_DELETE) begin
						for (j = p; j + 1 < list_len; j++)
							list_mem[ADDR_W'(j)] = list_mem[ADDR_W'(j + 1)];
						list_len--;
					end
				end
			end
			default: r.status = STAT_RANGE;
		endcase
		r.length = list_len[LEN_W-1:0];
		return r;
	endfunction

	task automatic push_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
		logic [VAL_W-1:0] val);
		in_item_t it;
		it.operation = op;
		it.position = pos;
		it.new_value = val;
		op_queue.push_back(it);
		if (op == OP_INSERT && int'(pos) <= plan_len && plan_len < DEPTH)
			plan_len++;
		else if (op == OP_DELETE && int'(pos) < plan_len)
			plan_len--;
	endtask

	// grow and shrink runs so the list reaches both full and empty
	task automatic push_random();
		int r;
		logic [OP_W-1:0] op;
		logic [POS_W-1:0] pos;
		r = $urandom_range(0, 99);
		if (plan_len == DEPTH && $urandom_range(0, 3) == 0)
			growing = 1'b0;
		else if (plan_len == 0 && $urandom_range(0, 3) == 0)
			growing = 1'b1;
		else if ($urandom_range(0, 59) == 0)
			growing = !growing;
		if (r < 6) begin
			op = OP_W'($urandom_range(OP_INSERT, OP_UNUSED));
			pos = POS_W'($urandom_range(0, 127));
		end else begin
			if (r < 21)
				op = OP_READ;
			else if (r < 31)
				op = growing ? OP_DELETE : OP_INSERT;
			else
				op = growing ? OP_INSERT : OP_DELETE;
			if (op == OP_INSERT)
				pos = POS_W'($urandom_range(0, plan_len));
			else if (plan_len == 0)
				pos = '0;
			else
				pos = POS_W'($urandom_range(0, plan_len - 1));
		end
		push_item(op, pos, $urandom);
	endtask

	task automatic report_bad(string what, out_item_t exp_r, out_item_t got_r);
		if (fail_count < REPORT_MAX)
			$display({"mismatch (%s): exp status %0d value %0d length %0d,",
				" got status %0d value %0d length %0d"},
				what, exp_r.status, exp_r.out_value, exp_r.length,
				got_r.status, got_r.out_value, got_r.length);
		fail_count++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
		end else begin
			if (in_valid && !in_stall)
				list_replies.push_back(list_apply(op_queue.pop_front()));
			if (in_valid && in_stall) begin
				in_valid <= 1'b1;
			end else if (op_queue.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
				in_valid <= 1'b1;
				in_item <= op_queue[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (list_replies.size() == 0) begin
				report_bad("no item pending", '0, out_item);
			end else if (out_item.status !== list_replies[0].status ||
					out_item.out_value !== list_replies[0].out_value ||
					out_item.length !== list_replies[0].length) begin
				report_bad("field", list_replies.pop_front(), out_item);
			end else begin
				void'(list_replies.pop_front());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int gap_plan[4];
		int stall_plan[4];
		int ph;
		gap_plan = '{0, 56, 0, 14};
		stall_plan = '{0, 0, 56, 14};
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (ph = 0; ph < 4; ph++) begin
			gap_pct = gap_plan[ph];
			stall_pct = stall_plan[ph];
			if (ph == 0) begin
				// empty list errors, unused code, far positions
				push_item(OP_READ, 0, 0);
				push_item(OP_DELETE, 0, 0);
				push_item(OP_INSERT, 1, 32'h1);
				push_item(OP_UNUSED, 0, 32'hffff_ffff);
				push_item(OP_INSERT, 127, 32'h5);
				// extremes of value, insert at head, tail and middle
				push_item(OP_INSERT, 0, 32'h8000_0000);
				push_item(OP_INSERT, 0, 32'h7fff_ffff);
				push_item(OP_INSERT, 2, 32'hffff_ffff);
				push_item(OP_INSERT, 1, 32'h0);
				push_item(OP_INSERT, 5, 32'h7);
				push_item(OP_READ, 0, 0);
				push_item(OP_READ, 1, 0);
				push_item(OP_READ, 2, 0);
				push_item(OP_READ, 3, 0);
				push_item(OP_READ, 4, 0);
				push_item(OP_DELETE, 3, 0);
				push_item(OP_DELETE, 0, 0);
				push_item(OP_READ, 127, 0);
				push_item(OP_DELETE, 64, 0);
				push_item(OP_UNUSED, 127, 32'h5a5a_5a5a);
				push_item(OP_READ, 0, 0);
			end
			repeat (ITEMS_PER_PHASE) push_random();
			while (op_queue.size() > 0 || list_replies.size() > 0)
				@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		fail_count += list_replies.size();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
